FILE: sv/notification_attribute_parser_macros.svh
// ----------------------------------------------------------------------------
// notification attribute parser assertion macros
// concurrent checks sampled on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef NOTIFICATION_ATTRIBUTE_PARSER_MACROS_SVH
`define NOTIFICATION_ATTRIBUTE_PARSER_MACROS_SVH

// same-cycle implication
`define NAP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nap check failed");

// next-cycle implication
`define NAP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nap check failed");

`endif

FILE: sv/nap_pkg.sv
// ----------------------------------------------------------------------------
// nap_pkg
// types and codes shared by the notification attribute parser
// ----------------------------------------------------------------------------
package nap_pkg;

	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_UID  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ATTR = 1'b1;

	localparam logic [7:0] CMD_GET_ATTR   = 8'h00;
	localparam logic [2:0] UID_BYTES      = 3'd4;
	localparam logic [7:0] MAX_ATTR_ID    = 8'd5;
	localparam logic [2:0] LAST_TRUNC_ID  = 3'd3;
	localparam logic [1:0] LEN_BYTES      = 2'd2;

	localparam logic [1:0] ST_MORE     = 2'd0;
	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_ERROR    = 2'd2;

	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_COMMAND   = 3'd1;
	localparam logic [2:0] ERR_UID       = 3'd2;
	localparam logic [2:0] ERR_ATTRIBUTE = 3'd3;
	localparam logic [2:0] ERR_SEQUENCE  = 3'd4;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd5;
	localparam logic [2:0] ERR_ARGUMENT  = 3'd6;

	typedef enum logic [2:0] {
		PH_COMMAND  = 3'd0,
		PH_UID      = 3'd1,
		PH_ID       = 3'd2,
		PH_LENGTH   = 3'd3,
		PH_VALUE    = 3'd4,
		PH_COMPLETE = 3'd5,
		PH_ERROR    = 3'd6
	} phase_t;

	typedef struct packed {
		logic       func;
		logic [7:0] byte_value;
		logic       chunk_end;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] error_kind;
		logic       value_write;
		logic [2:0] attr_id;
		logic [9:0] value_index;
		logic [7:0] value_data;
		logic       attribute_done;
		logic [9:0] stored_length;
		logic       truncated;
	} rsp_t;

endpackage

FILE: sv/notification_attribute_parser.sv
// an accepted request is held in the request register, which feeds the result register
// one request per cycle unless stalled; the single parser update stage takes one byte a cycle
// a stalled result holds the request register; input stalls once both registers are full
// reset: parser unarmed, data bytes answer an argument error until a start request
// reset: expected uid and expected attribute mask clear to zero
// ----------------------------------------------------------------------------
// notification_attribute_parser
// byte-wise parser for get-notification-attributes responses
// ----------------------------------------------------------------------------
module notification_attribute_parser #(
	parameter int APP_ID_CAP     = 64,
	parameter int TITLE_CAP      = 64,
	parameter int SUBTITLE_CAP   = 64,
	parameter int MESSAGE_CAP    = 256,
	parameter int SIZE_FIELD_CAP = 15,
	parameter int DATE_CAP       = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  nap_pkg::req_t                    req_data,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output nap_pkg::rsp_t                    rsp_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [nap_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                      cfg_data
);
	import nap_pkg::*;

	logic [31:0] exp_uid_q;
	logic [5:0]  exp_attr_q;
	logic        valid_s1;
	req_t        item_s1;
	logic        free;
	logic        adv;
	rsp_t        res;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && free;
	assign req_ready = !valid_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_uid_q  <= '0;
			exp_attr_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IDX_UID:  exp_uid_q  <= cfg_data;
				CFG_IDX_ATTR: exp_attr_q <= cfg_data[5:0];
				default:      exp_uid_q  <= exp_uid_q;
			endcase
		end
	end

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req_data;
		end
	end

	nap_core #(
		.APP_ID_CAP     (APP_ID_CAP),
		.TITLE_CAP      (TITLE_CAP),
		.SUBTITLE_CAP   (SUBTITLE_CAP),
		.MESSAGE_CAP    (MESSAGE_CAP),
		.SIZE_FIELD_CAP (SIZE_FIELD_CAP),
		.DATE_CAP       (DATE_CAP)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.item     (item_s1),
		.exp_uid  (exp_uid_q),
		.exp_attr (exp_attr_q),
		.res      (res)
	);

	nap_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.res       (res),
		.free      (free),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

FILE: sv/nap_core.sv
// ----------------------------------------------------------------------------
// nap_core
// parser state registers and the per-byte state update and result logic
// ----------------------------------------------------------------------------
module nap_core #(
	parameter int APP_ID_CAP     = 64,
	parameter int TITLE_CAP      = 64,
	parameter int SUBTITLE_CAP   = 64,
	parameter int MESSAGE_CAP    = 256,
	parameter int SIZE_FIELD_CAP = 15,
	parameter int DATE_CAP       = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  nap_pkg::req_t item,
	input  logic [31:0]   exp_uid,
	input  logic [5:0]    exp_attr,
	output nap_pkg::rsp_t res
);
	import nap_pkg::*;

	phase_t      phase_q, phase_n;
	logic [31:0] acc_q, acc_n;
	logic [2:0]  ucnt_q, ucnt_n;
	logic [2:0]  cur_q, cur_n;
	logic [15:0] len_q, len_n;
	logic [15:0] cnt_q, cnt_n;
	logic [1:0]  lbc_q, lbc_n;
	logic [5:0]  recv_q, recv_n;
	logic [2:0]  lerr_q, lerr_n;

	logic [9:0]  cap;
	logic [5:0]  byte_mask;

	always_comb begin
		case (cur_q)
			3'd0:    cap = 10'(APP_ID_CAP);
			3'd1:    cap = 10'(TITLE_CAP);
			3'd2:    cap = 10'(SUBTITLE_CAP);
			3'd3:    cap = 10'(MESSAGE_CAP);
			3'd4:    cap = 10'(SIZE_FIELD_CAP);
			3'd5:    cap = 10'(DATE_CAP);
			default: cap = 10'd0;
		endcase
	end

	assign byte_mask = 6'b000001 << item.byte_value[2:0];

	always_comb begin
		logic [1:0]  st;
		logic        fin;
		logic [15:0] fin_len;
		logic        fail;
		logic [2:0]  fail_code;
		logic        over;
		res       = '0;
		st        = ST_MORE;
		fin       = 1'b0;
		fin_len   = '0;
		fail      = 1'b0;
		fail_code = ERR_OK;
		over      = 1'b0;
		phase_n   = phase_q;
		acc_n     = acc_q;
		ucnt_n    = ucnt_q;
		cur_n     = cur_q;
		len_n     = len_q;
		cnt_n     = cnt_q;
		lbc_n     = lbc_q;
		recv_n    = recv_q;
		lerr_n    = lerr_q;
		if (item.func) begin
			phase_n = PH_COMMAND;
			acc_n   = '0;
			ucnt_n  = '0;
			cur_n   = '0;
			len_n   = '0;
			cnt_n   = '0;
			lbc_n   = '0;
			recv_n  = '0;
			lerr_n  = ERR_OK;
			if (exp_attr == 6'd0) begin
				fail      = 1'b1;
				fail_code = ERR_ARGUMENT;
			end
		end else begin
			case (phase_q)
				PH_COMMAND: begin
					if (item.byte_value != CMD_GET_ATTR) begin
						fail      = 1'b1;
						fail_code = ERR_COMMAND;
					end else begin
						acc_n   = '0;
						ucnt_n  = '0;
						phase_n = PH_UID;
					end
				end
				PH_UID: begin
					acc_n  = acc_q | ({24'd0, item.byte_value} << {ucnt_q[1:0], 3'b000});
					ucnt_n = ucnt_q + 3'd1;
					if (ucnt_n >= UID_BYTES) begin
						if (acc_n != exp_uid) begin
							fail      = 1'b1;
							fail_code = ERR_UID;
						end else begin
							phase_n = PH_ID;
						end
					end
				end
				PH_ID: begin
					if (item.byte_value > MAX_ATTR_ID) begin
						fail      = 1'b1;
						fail_code = ERR_ATTRIBUTE;
					end else if ((exp_attr & byte_mask) == 6'd0 ||
							(recv_q & byte_mask) != 6'd0) begin
						fail      = 1'b1;
						fail_code = ERR_SEQUENCE;
					end else begin
						cur_n   = item.byte_value[2:0];
						len_n   = '0;
						cnt_n   = '0;
						lbc_n   = '0;
						phase_n = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					len_n = len_q | ({8'd0, item.byte_value} << {lbc_q[0], 3'b000});
					lbc_n = lbc_q + 2'd1;
					if (lbc_n >= LEN_BYTES) begin
						if (len_n == 16'd0) begin
							fin     = 1'b1;
							fin_len = len_n;
						end else begin
							phase_n = PH_VALUE;
						end
					end
				end
				PH_VALUE: begin
					if (cnt_q < {6'd0, cap}) begin
						res.value_write  = 1'b1;
						res.attr_id      = cur_q;
						res.value_index  = cnt_q[9:0];
						res.value_data   = item.byte_value;
					end
					cnt_n = cnt_q + 16'd1;
					if (cnt_n == len_q) begin
						fin     = 1'b1;
						fin_len = len_q;
					end
				end
				PH_COMPLETE: begin
					fail      = 1'b1;
					fail_code = ERR_SEQUENCE;
				end
				default: begin
					st = ST_ERROR;
				end
			endcase
		end
		// attribute end
		if (fin) begin
			over                 = fin_len > {6'd0, cap};
			res.attr_id          = cur_q;
			res.attribute_done   = 1'b1;
			res.stored_length    = over ? cap : fin_len[9:0];
			res.truncated        = over;
			if (over && cur_q > LAST_TRUNC_ID) begin
				fail      = 1'b1;
				fail_code = ERR_OVERFLOW;
			end else begin
				recv_n = recv_q | (6'b000001 << cur_q);
				if ((recv_n & exp_attr) == exp_attr) begin
					if (!item.chunk_end) begin
						fail      = 1'b1;
						fail_code = ERR_SEQUENCE;
					end else begin
						phase_n = PH_COMPLETE;
						st      = ST_COMPLETE;
					end
				end else begin
					phase_n = PH_ID;
					cur_n   = '0;
					len_n   = '0;
					cnt_n   = '0;
					lbc_n   = '0;
					st      = ST_MORE;
				end
			end
		end
		if (fail) begin
			phase_n = PH_ERROR;
			lerr_n  = fail_code;
			st      = ST_ERROR;
		end
		res.status     = st;
		res.error_kind = (st == ST_ERROR) ? lerr_n : ERR_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ERROR;
			acc_q   <= '0;
			ucnt_q  <= '0;
			cur_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			lbc_q   <= '0;
			recv_q  <= '0;
			lerr_q  <= ERR_ARGUMENT;
		end else if (adv) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			ucnt_q  <= ucnt_n;
			cur_q   <= cur_n;
			len_q   <= len_n;
			cnt_q   <= cnt_n;
			lbc_q   <= lbc_n;
			recv_q  <= recv_n;
			lerr_q  <= lerr_n;
		end
	end

endmodule

FILE: sv/nap_out_stage.sv
// ----------------------------------------------------------------------------
// nap_out_stage
// result register with valid/ready handshake toward the consumer
// ----------------------------------------------------------------------------
module nap_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  nap_pkg::rsp_t res,
	output logic          free,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output nap_pkg::rsp_t rsp_data
);
	import nap_pkg::*;

	logic valid_q;
	rsp_t data_q;

	assign free      = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign rsp_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

endmodule

FILE: sv/nap_checker.sv
// ----------------------------------------------------------------------------
// nap_checker
// port-level checks on the parser result channel, bound to the top level
// ----------------------------------------------------------------------------
`include "notification_attribute_parser_macros.svh"

module nap_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input nap_pkg::rsp_t rsp_data
);
	import nap_pkg::*;

	`NAP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
	`NAP_ASSERT_NOW(a_ok_kind, rsp_valid && rsp_data.status != ST_ERROR, rsp_data.error_kind == ERR_OK)
	`NAP_ASSERT_NOW(a_err_kind, rsp_valid && rsp_data.status == ST_ERROR, rsp_data.error_kind != ERR_OK)
	`NAP_ASSERT_NOW(a_write_zero, rsp_valid && !rsp_data.value_write, rsp_data.value_index == 10'd0 && rsp_data.value_data == 8'd0)
	`NAP_ASSERT_NOW(a_done_zero, rsp_valid && !rsp_data.attribute_done, rsp_data.stored_length == 10'd0 && !rsp_data.truncated)

endmodule

bind notification_attribute_parser nap_checker u_nap_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);

FILE: tb/notification_attribute_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// notification_attribute_parser_tb
// drives byte-wise attribute responses through the parser and checks every
// result against a cycle-free parser model kept in the bench, with random
// idling on both sides, a long result stall and several register settings
// ----------------------------------------------------------------------------
module notification_attribute_parser_tb;
	import nap_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int STALL_CYCLES = 200;
	localparam int RUN_LIMIT_CYCLES = 400000;

	localparam logic [9:0] APP_ID_CAP     = 10'd64;
	localparam logic [9:0] TITLE_CAP      = 10'd64;
	localparam logic [9:0] SUBTITLE_CAP   = 10'd64;
	localparam logic [9:0] MESSAGE_CAP    = 10'd256;
	localparam logic [9:0] SIZE_FIELD_CAP = 10'd15;
	localparam logic [9:0] DATE_CAP       = 10'd16;

	logic                   clk;
	logic                   arst_n;
	logic                   req_valid;
	logic                   req_ready;
	req_t                   req_data;
	logic                   rsp_valid;
	logic                   rsp_ready = 1'b0;
	rsp_t                   rsp_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]            cfg_data;

	notification_attribute_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// parser model state and register copies
	logic [31:0] cfg_uid;
	logic [5:0]  cfg_mask;
	phase_t      parse_phase;
	logic [31:0] uid_acc;
	logic [2:0]  uid_cnt;
	logic [2:0]  cur_attr;
	logic [15:0] val_len;
	logic [15:0] val_cnt;
	logic [1:0]  len_cnt;
	logic [5:0]  rcvd_mask;
	logic [2:0]  last_err;

	rsp_t        expected_rsp_q[$];
	req_t        frame_q[$];
	int unsigned mismatch_count = 0;
	int unsigned sent_count;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	logic        stall_trigger;
	logic        stall_seen = 1'b0;
	int unsigned stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(CLK_PERIOD * RUN_LIMIT_CYCLES);
		$display("notification_attribute_parser_tb: FAIL");
		$finish;
	end

	function automatic logic [9:0] attr_capacity(input logic [2:0] id);
		case (id)
			3'd0: return APP_ID_CAP;
			3'd1: return TITLE_CAP;
			3'd2: return SUBTITLE_CAP;
			3'd3: return MESSAGE_CAP;
			3'd4: return SIZE_FIELD_CAP;
			3'd5: return DATE_CAP;
			default: return 10'd0;
		endcase
	endfunction

	function automatic logic [1:0] enter_error(input logic [2:0] code);
		parse_phase = PH_ERROR;
		last_err = code;
		return ST_ERROR;
	endfunction

	function automatic void clear_record();
		cur_attr = 3'd0;
		val_len = 16'd0;
		val_cnt = 16'd0;
		len_cnt = 2'd0;
	endfunction

	function automatic rsp_t predict_rsp(input req_t rq);
		rsp_t       r;
		logic [1:0] st;
		logic       attr_end;
		logic [9:0] cap;
		logic       over;
		r = '0;
		st = ST_MORE;
		attr_end = 1'b0;
		if (rq.func) begin
			parse_phase = PH_COMMAND;
			uid_acc = 32'd0;
			uid_cnt = 3'd0;
			clear_record();
			rcvd_mask = 6'd0;
			last_err = ERR_OK;
			if (cfg_mask == 6'd0)
				st = enter_error(ERR_ARGUMENT);
		end else begin
			case (parse_phase)
				PH_COMMAND: begin
					if (rq.byte_value != CMD_GET_ATTR) begin
						st = enter_error(ERR_COMMAND);
					end else begin
						uid_acc = 32'd0;
						uid_cnt = 3'd0;
						parse_phase = PH_UID;
					end
				end
				PH_UID: begin
					uid_acc = uid_acc | ({24'd0, rq.byte_value} << (8 * uid_cnt[1:0]));
					uid_cnt = uid_cnt + 3'd1;
					if (uid_cnt >= UID_BYTES) begin
						if (uid_acc != cfg_uid)
							st = enter_error(ERR_UID);
						else
							parse_phase = PH_ID;
					end
				end
				PH_ID: begin
					if (rq.byte_value > MAX_ATTR_ID) begin
						st = enter_error(ERR_ATTRIBUTE);
					end else if (!cfg_mask[rq.byte_value[2:0]] ||
						rcvd_mask[rq.byte_value[2:0]]) begin
						st = enter_error(ERR_SEQUENCE);
					end else begin
						clear_record();
						cur_attr = rq.byte_value[2:0];
						parse_phase = PH_LENGTH;
					end
				end
				PH_LENGTH: begin
					val_len = val_len | ({8'd0, rq.byte_value} << (8 * len_cnt[0]));
					len_cnt = len_cnt + 2'd1;
					if (len_cnt >= LEN_BYTES) begin
						if (val_len == 16'd0)
							attr_end = 1'b1;
						else
							parse_phase = PH_VALUE;
					end
				end
				PH_VALUE: begin
					if (val_cnt < {6'd0, attr_capacity(cur_attr)}) begin
						r.value_write = 1'b1;
						r.attr_id = cur_attr;
						r.value_index = val_cnt[9:0];
						r.value_data = rq.byte_value;
					end
					val_cnt = val_cnt + 16'd1;
					if (val_cnt == val_len)
						attr_end = 1'b1;
				end
				PH_COMPLETE: st = enter_error(ERR_SEQUENCE);
				default: st = ST_ERROR;
			endcase
		end
		if (attr_end) begin
			cap = attr_capacity(cur_attr);
			over = val_len > {6'd0, cap};
			r.attr_id = cur_attr;
			r.attribute_done = 1'b1;
			r.stored_length = over ? cap : val_len[9:0];
			r.truncated = over;
			if (over && cur_attr > LAST_TRUNC_ID) begin
				st = enter_error(ERR_OVERFLOW);
			end else begin
				rcvd_mask = rcvd_mask | (6'd1 << cur_attr);
				if ((rcvd_mask & cfg_mask) == cfg_mask) begin
					if (!rq.chunk_end) begin
						st = enter_error(ERR_SEQUENCE);
					end else begin
						parse_phase = PH_COMPLETE;
						st = ST_COMPLETE;
					end
				end else begin
					parse_phase = PH_ID;
					clear_record();
				end
			end
		end
		r.status = st;
		r.error_kind = (st == ST_ERROR) ? last_err : ERR_OK;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			mismatch_count++;
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
		end
	endfunction

	// result monitor
	always @(posedge clk) begin : rsp_monitor
		rsp_t exp_r;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none actual %p", $time, rsp_data);
			end else begin
				exp_r = expected_rsp_q.pop_front();
				check_field("status", 16'(exp_r.status), 16'(rsp_data.status));
				check_field("error_kind", 16'(exp_r.error_kind), 16'(rsp_data.error_kind));
				check_field("value_write", 16'(exp_r.value_write),
					16'(rsp_data.value_write));
				check_field("attr_id", 16'(exp_r.attr_id), 16'(rsp_data.attr_id));
				check_field("value_index", 16'(exp_r.value_index),
					16'(rsp_data.value_index));
				check_field("value_data", 16'(exp_r.value_data), 16'(rsp_data.value_data));
				check_field("attribute_done", 16'(exp_r.attribute_done),
					16'(rsp_data.attribute_done));
				check_field("stored_length", 16'(exp_r.stored_length),
					16'(rsp_data.stored_length));
				check_field("truncated", 16'(exp_r.truncated), 16'(rsp_data.truncated));
			end
		end
	end

	// receiver ready and long stall control
	always @(posedge clk) begin : rsp_ready_ctrl
		if (stall_trigger != stall_seen) begin
			stall_seen = stall_trigger;
			stall_left = STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(input req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= item;
		do @(posedge clk); while (!req_ready);
		expected_rsp_q.push_back(predict_rsp(item));
		sent_count++;
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_IDX_UID)
			cfg_uid = val;
		else
			cfg_mask = val[5:0];
	endtask

	task automatic configure(input logic [31:0] uid, input logic [5:0] mask);
		wait_idle();
		write_reg(CFG_IDX_UID, uid);
		write_reg(CFG_IDX_ATTR, {26'd0, mask});
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b);
		req_t item;
		item.func = 1'b0;
		item.byte_value = b;
		item.chunk_end = ($urandom_range(7) == 0);
		frame_q.push_back(item);
	endtask

	task automatic add_header(input logic [31:0] uid);
		req_t item;
		item.func = 1'b1;
		item.byte_value = 8'($urandom_range(255));
		item.chunk_end = 1'($urandom_range(1));
		frame_q.push_back(item);
		add_byte(CMD_GET_ATTR);
		for (int i = 0; i < 4; i++)
			add_byte(uid[8*i +: 8]);
	endtask

	task automatic add_record(input logic [7:0] id, input logic [15:0] len);
		add_byte(id);
		add_byte(len[7:0]);
		add_byte(len[15:8]);
		for (int i = 0; i < len; i++)
			add_byte(8'($urandom_range(255)));
	endtask

	task automatic send_frame(input logic last_end);
		req_t item;
		if (frame_q.size() != 0) begin
			item = frame_q[frame_q.size() - 1];
			item.chunk_end = last_end;
			frame_q[frame_q.size() - 1] = item;
		end
		for (int i = 0; i < frame_q.size(); i++)
			send_item(frame_q[i]);
		frame_q.delete();
	endtask

	function automatic logic [15:0] pick_length(input logic [2:0] id);
		logic [9:0]  cap;
		int unsigned r;
		cap = attr_capacity(id);
		r = $urandom_range(99);
		if (r < 55)
			return 16'($urandom_range(6));
		else if (r < 80)
			return 16'($urandom_range((cap > 10'd64) ? 32 : cap));
		else if (r < 95)
			return 16'($urandom_range(cap - 1, cap + 1));
		else if (id <= LAST_TRUNC_ID)
			return 16'(cap + $urandom_range(1, 20));
		else
			return 16'(cap + $urandom_range(1, 3));
	endfunction

	// data before any start, then a start with an empty mask
	task automatic test_unarmed();
		req_t item;
		item.func = 1'b0;
		item.byte_value = 8'hFF;
		item.chunk_end = 1'b1;
		send_item(item);
		item.func = 1'b1;
		item.byte_value = 8'h00;
		item.chunk_end = 1'b0;
		send_item(item);
	endtask

	task automatic test_command_error();
		add_header(cfg_uid);
		frame_q = frame_q[0:0];
		add_byte(8'hFF);
		send_frame(1'b1);
	endtask

	task automatic test_uid_mismatch();
		add_header(cfg_uid ^ 32'h8000_0000);
		send_frame(1'b0);
	endtask

	task automatic test_attribute_id();
		add_header(cfg_uid);
		add_byte(MAX_ATTR_ID + 8'd1);
		send_frame(1'b1);
	endtask

	task automatic test_unexpected_id();
		add_header(cfg_uid);
		add_byte(8'd0);
		send_frame(1'b1);
	endtask

	task automatic test_repeated_id();
		add_header(cfg_uid);
		add_record(8'd5, 16'd0);
		add_byte(8'd5);
		send_frame(1'b1);
	endtask

	// zero-length records complete the response, then one byte too many
	task automatic test_completion();
		req_t item;
		add_header(cfg_uid);
		add_record(8'd5, 16'd0);
		add_record(8'd4, 16'd0);
		send_frame(1'b1);
		item.func = 1'b0;
		item.byte_value = 8'h00;
		item.chunk_end = 1'b1;
		send_item(item);
	endtask

	task automatic test_early_completion();
		add_header(cfg_uid);
		add_record(8'd5, 16'd0);
		add_record(8'd4, 16'd0);
		send_frame(1'b0);
	endtask

	task automatic test_overflow();
		add_header(cfg_uid);
		add_record(8'd4, {6'd0, SIZE_FIELD_CAP} + 16'd1);
		send_frame(1'b1);
	endtask

	// long result stall while a message record streams in
	task automatic test_backpressure();
		configure($urandom, 6'h08);
		stall_trigger <= ~stall_trigger;
		add_header(cfg_uid);
		add_record(8'd3, 16'd40);
		send_frame(1'b1);
	endtask

	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned target;
		int unsigned frame_cnt;
		int unsigned r;
		int unsigned defect;
		int unsigned j;
		int unsigned k;
		logic [2:0]  ids[$];
		logic [2:0]  t;
		logic [31:0] uid;
		logic [5:0]  mask;
		req_t        item;
		target = sent_count + n_items;
		frame_cnt = 0;
		while (sent_count < target) begin
			if (frame_cnt % 4 == 0) begin
				r = $urandom_range(9);
				uid = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
				r = $urandom_range(19);
				mask = (r == 0) ? 6'd0 : (r < 4) ? 6'h3F : 6'($urandom_range(1, 63));
				configure(uid, mask);
			end
			frame_cnt++;
			r = $urandom_range(99);
			if (r < 95) begin
				ids.delete();
				for (int i = 0; i < 6; i++)
					if (cfg_mask[i])
						ids.push_back(3'(i));
				for (int i = ids.size() - 1; i > 0; i--) begin
					j = $urandom_range(i);
					t = ids[i];
					ids[i] = ids[j];
					ids[j] = t;
				end
				add_header(cfg_uid);
				foreach (ids[i])
					add_record({5'd0, ids[i]}, pick_length(ids[i]));
				defect = (r < 75) ? 4 : $urandom_range(3);
				case (defect)
					0: begin
						k = $urandom_range(1, frame_q.size() - 1);
						item = frame_q[k];
						item.byte_value = 8'($urandom_range(255));
						frame_q[k] = item;
					end
					1: begin
						k = $urandom_range(1, frame_q.size() - 1);
						repeat (k) frame_q.pop_back();
					end
					3: begin
						repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(255)));
					end
					default: ;
				endcase
				send_frame(defect != 2);
			end else begin
				repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(255)));
				send_frame(1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = 32'd0;
		cfg_uid = 32'd0;
		cfg_mask = 6'd0;
		parse_phase = PH_ERROR;
		uid_acc = 32'd0;
		uid_cnt = 3'd0;
		clear_record();
		rcvd_mask = 6'd0;
		last_err = ERR_ARGUMENT;
		sent_count = 0;
		stall_trigger = 1'b0;
		send_idle_pct = 10;
		recv_idle_pct = 81;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unarmed();
		configure(32'hFFFF_FFFF, 6'h30);
		test_command_error();
		test_uid_mismatch();
		test_attribute_id();
		test_unexpected_id();
		test_repeated_id();
		test_completion();
		test_early_completion();
		test_overflow();
		test_backpressure();

		test_random_traffic(150);
		send_idle_pct = 81;
		recv_idle_pct = 10;
		test_random_traffic(150);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(150);

		wait_idle();
		repeat (8) @(posedge clk);
		if (expected_rsp_q.size() != 0) begin
			$display("%0t: pending results expected 0 actual %0d", $time,
				expected_rsp_q.size());
		end
		if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
			$display("notification_attribute_parser_tb: PASS");
		end else begin
			$display("notification_attribute_parser_tb: FAIL");
		end
		$finish;
	end

endmodule

FILE: notification_attribute_parser.f
+incdir+sv
sv/nap_pkg.sv
sv/nap_core.sv
sv/nap_out_stage.sv
sv/notification_attribute_parser.sv
sv/nap_checker.sv
tb/notification_attribute_parser_tb.sv
